>>> hw/rtl/rtoc_pkg.sv
// ----------------------------------------------------------------------------
// rtoc_pkg
// Shared types and constants of the realtime occupancy tracker and cpu picker.
// ----------------------------------------------------------------------------
package rtoc_pkg;

  localparam int NUM_CPUS_DEF = 64;
  localparam int CPU_FW       = 6;
  localparam int TIME_W       = 64;
  localparam int MASK_W       = 64;
  localparam int CNT_W        = 7;
  localparam int PRIO_W       = 9;
  localparam int LEVEL_W      = 3;
  localparam int IN_TDATA_W   = 216;
  localparam int OUT_TDATA_W  = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic signed [PRIO_W-1:0] RT_PRIO_LIMIT = 9'sd100;

  localparam logic [TIME_W-1:0] DRAIN_INTERVAL_RST = 64'd1000000;
  localparam logic [CNT_W-1:0]  CPU_COUNT_RST      = 7'd64;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_REENQ    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_REENQ    = 2'd3;

  // operation codes
  localparam logic OP_SWITCH = 1'b0;
  localparam logic OP_PICK   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_GATE,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [CPU_FW-1:0] cpu;
  } scan_res_t;

endpackage

>>> hw/rtl/rtoc_ts_mem.sv
// ----------------------------------------------------------------------------
// rtoc_ts_mem
// Per-cpu last-drain timestamp memory, one write and one registered read port.
// Entries never written read as zero.
// ----------------------------------------------------------------------------
module rtoc_ts_mem #(
  parameter int NUM_CPUS = rtoc_pkg::NUM_CPUS_DEF,
  parameter int CPU_IW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [CPU_IW-1:0]           rd_addr,
  output logic [rtoc_pkg::TIME_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [CPU_IW-1:0]           wr_addr,
  input  logic [rtoc_pkg::TIME_W-1:0] wr_data
);
  import rtoc_pkg::*;

  logic [TIME_W-1:0]   mem [NUM_CPUS];
  logic [NUM_CPUS-1:0] vld_r;
  logic [TIME_W-1:0]   rdata_r;
  logic                rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

>>> hw/rtl/rtoc_scan.sv
// ----------------------------------------------------------------------------
// rtoc_scan
// Bit-serial cpu scanner: tests one cpu id per cycle for the cache-domain
// pass and the flat pass together, stopping early on a cache-domain hit.
// ----------------------------------------------------------------------------
module rtoc_scan #(
  parameter int NUM_CPUS = rtoc_pkg::NUM_CPUS_DEF,
  parameter int CPU_IW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        llc_known,
  input  logic [rtoc_pkg::MASK_W-1:0] llc_mask,
  input  logic [rtoc_pkg::MASK_W-1:0] affinity,
  input  logic [NUM_CPUS-1:0]         occupied,
  input  logic [rtoc_pkg::CNT_W-1:0]  cpu_count,
  output rtoc_pkg::scan_res_t         res
);
  import rtoc_pkg::*;

  logic                busy_r;
  logic [CPU_IW-1:0]   c_r;
  logic                flat_found_r;
  logic [CPU_IW-1:0]   flat_cpu_r;
  logic [NUM_CPUS-1:0] llc_v;
  logic [NUM_CPUS-1:0] aff_v;
  logic                free_c;
  logic                llc_hit;
  logic                flat_hit;
  logic                last_c;

  assign llc_v    = llc_mask[NUM_CPUS-1:0];
  assign aff_v    = affinity[NUM_CPUS-1:0];
  assign free_c   = aff_v[c_r] & ~occupied[c_r];
  assign llc_hit  = llc_known & llc_v[c_r] & free_c;
  assign flat_hit = free_c & (CNT_W'(c_r) < cpu_count);
  assign last_c   = (c_r == CPU_IW'(NUM_CPUS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      c_r          <= '0;
      flat_found_r <= 1'b0;
      flat_cpu_r   <= '0;
    end else if (start) begin
      busy_r       <= 1'b1;
      c_r          <= '0;
      flat_found_r <= 1'b0;
    end else if (busy_r) begin
      if (llc_hit || last_c) begin
        busy_r <= 1'b0;
      end
      c_r <= c_r + 1'b1;
      if (flat_hit && !flat_found_r) begin
        flat_found_r <= 1'b1;
        flat_cpu_r   <= c_r;
      end
    end
  end

  always_comb begin
    res.done  = busy_r & (llc_hit | last_c);
    res.found = 1'b0;
    res.cpu   = '0;
    if (llc_hit) begin
      res.found = 1'b1;
      res.cpu   = CPU_FW'(c_r);
    end else if (flat_found_r) begin
      res.found = 1'b1;
      res.cpu   = CPU_FW'(flat_cpu_r);
    end else if (flat_hit) begin
      res.found = 1'b1;
      res.cpu   = CPU_FW'(c_r);
    end
  end

endmodule

>>> hw/rtl/rt_occupancy_tracker_cpu_picker.sv
// ----------------------------------------------------------------------------
// rt_occupancy_tracker_cpu_picker
// Realtime occupancy bitmap with rate-limited drain requests and a picker
// that returns the lowest free allowed cpu, cache domain first.
// ----------------------------------------------------------------------------
// switch event: states S_READ (timestamp read), S_SUM and S_GATE (two passes
//   through the shared 64-bit adder for the interval check), result valid in S_OUT
// pick request: the scanner in S_SCAN tests one cpu id per cycle until done;
//   one item at a time, next item taken after the result transfer
// reset: occupancy and all timestamps read as zero, registers at defaults
module rt_occupancy_tracker_cpu_picker #(
  parameter int NUM_CPUS = rtoc_pkg::NUM_CPUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // op
  input  logic [0:0]                       in_tuser,
  // cpu, next_prio, now, local_queued, level_queued, affinity,
  // origin_llc_known, origin_llc_mask, zero pad
  input  logic [rtoc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // took_over, drained, reenq_local, reenq_levels, pick_found, pick_cpu, zero pad
  output logic [rtoc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [rtoc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtoc_pkg::TIME_W-1:0]      cfg_wdata
);
  import rtoc_pkg::*;

  localparam int CPU_IW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  state_t state_r, state_nxt;

  // configuration
  logic [TIME_W-1:0] interval_r;
  logic [CNT_W-1:0]  cpu_count_r;
  logic              local_sup_r;
  logic              queue_sup_r;

  // captured item
  logic                     op_r;
  logic [CPU_FW-1:0]        cpu_r;
  logic signed [PRIO_W-1:0] prio_r;
  logic [TIME_W-1:0]        now_r;
  logic                     lq_r;
  logic [LEVEL_W-1:0]       levq_r;
  logic [MASK_W-1:0]        aff_r;
  logic                     known_r;
  logic [MASK_W-1:0]        llc_r;

  logic [NUM_CPUS-1:0] occ_r;
  logic [TIME_W-1:0]   sum_r;
  logic                last_zero_r;

  // result register
  logic               took_r;
  logic               drained_r;
  logic               rl_r;
  logic [LEVEL_W-1:0] rlev_r;
  logic               pfound_r;
  logic [CPU_FW-1:0]  pcpu_r;

  logic              accept;
  logic              rd_en;
  logic              scan_start;
  logic [TIME_W-1:0] rd_data;
  scan_res_t         scan_res;

  // shared adder
  logic              add_sub;
  logic [TIME_W-1:0] add_a;
  logic [TIME_W-1:0] add_b;
  logic [TIME_W-1:0] add_y;

  // switch decision
  logic [CPU_IW-1:0] idx;
  logic              in_range;
  logic              is_rt;
  logic              gate_open;
  logic              any_queued;
  logic              ran;
  logic              do_drain;
  logic              mem_we;

  assign accept = in_tvalid & in_tready;
  assign idx    = cpu_r[CPU_IW-1:0];
  assign in_range = ({1'b0, cpu_r} < (CPU_FW + 1)'(NUM_CPUS));
  assign is_rt    = (prio_r < RT_PRIO_LIMIT);

  assign add_y = add_a + (add_b ^ {TIME_W{add_sub}}) + TIME_W'(add_sub);

  assign gate_open  = last_zero_r | add_y[TIME_W-1];
  assign any_queued = lq_r | (levq_r != '0);
  assign ran        = local_sup_r | queue_sup_r;
  assign do_drain   = in_range & is_rt & gate_open & any_queued & ran;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser[0] == OP_PICK) ? S_SCAN : S_READ;
        end
      end
      S_READ: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_GATE;
      S_GATE: state_nxt = S_OUT;
      S_SCAN: begin
        if (scan_res.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    rd_en      = 1'b0;
    scan_start = 1'b0;
    mem_we     = 1'b0;
    add_sub    = 1'b0;
    add_a      = rd_data;
    add_b      = interval_r;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        scan_start = in_tvalid & (in_tuser[0] == OP_PICK);
      end
      S_READ: rd_en = 1'b1;
      S_SUM: begin
        add_a = rd_data;
        add_b = interval_r;
      end
      S_GATE: begin
        // last + interval - now, sign bit gives the wrapping compare
        add_sub = 1'b1;
        add_a   = sum_r;
        add_b   = now_r;
        mem_we  = do_drain;
      end
      S_SCAN: ;
      S_OUT:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      interval_r  <= DRAIN_INTERVAL_RST;
      cpu_count_r <= CPU_COUNT_RST;
      local_sup_r <= 1'b1;
      queue_sup_r <= 1'b1;
      occ_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DRAIN_INTERVAL: interval_r  <= cfg_wdata;
          CFG_CPU_COUNT:      cpu_count_r <= cfg_wdata[CNT_W-1:0];
          CFG_LOCAL_REENQ:    local_sup_r <= cfg_wdata[0];
          CFG_QUEUE_REENQ:    queue_sup_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == S_GATE && in_range) begin
        occ_r[idx] <= is_rt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_tuser[0];
      cpu_r   <= in_tdata[5:0];
      prio_r  <= in_tdata[14:6];
      now_r   <= in_tdata[78:15];
      lq_r    <= in_tdata[79];
      levq_r  <= in_tdata[82:80];
      aff_r   <= in_tdata[146:83];
      known_r <= in_tdata[147];
      llc_r   <= in_tdata[211:148];
    end
    if (state_r == S_SUM) begin
      sum_r       <= add_y;
      last_zero_r <= (rd_data == '0);
    end
    if (state_r == S_GATE) begin
      took_r    <= in_range & is_rt & ~occ_r[idx];
      drained_r <= do_drain;
      rl_r      <= in_range & is_rt & gate_open & any_queued & local_sup_r;
      rlev_r    <= (in_range & is_rt & gate_open & any_queued & queue_sup_r) ?
                   levq_r : '0;
      pfound_r  <= 1'b0;
      pcpu_r    <= '0;
    end
    if (state_r == S_SCAN && scan_res.done) begin
      took_r    <= 1'b0;
      drained_r <= 1'b0;
      rl_r      <= 1'b0;
      rlev_r    <= '0;
      pfound_r  <= scan_res.found;
      pcpu_r    <= scan_res.cpu;
    end
  end

  assign out_tdata = {3'b000, pcpu_r, pfound_r, rlev_r, rl_r, drained_r, took_r};

  rtoc_ts_mem #(
    .NUM_CPUS (NUM_CPUS),
    .CPU_IW   (CPU_IW)
  ) u_ts_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (idx),
    .wr_data (now_r)
  );

  rtoc_scan #(
    .NUM_CPUS (NUM_CPUS),
    .CPU_IW   (CPU_IW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .llc_known (known_r),
    .llc_mask  (llc_r),
    .affinity  (aff_r),
    .occupied  (occ_r),
    .cpu_count (cpu_count_r),
    .res       (scan_res)
  );

  // the scanner only finishes while a pick is in flight
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (state_r == S_SCAN && op_r == OP_PICK))
    else $error("scanner finished outside a pick");

  // a timestamp write only comes from a switch event decision
  a_write_on_switch: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_GATE && op_r == OP_SWITCH))
    else $error("timestamp written outside a switch decision");

  // a drain only runs with some reenqueue mode available
  a_drain_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && drained_r) |-> (local_sup_r || queue_sup_r))
    else $error("drain reported without a reenqueue mode");

  // pick results never carry switch flags
  a_pick_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && pfound_r) |-> (!took_r && !drained_r && !rl_r))
    else $error("pick result carries switch flags");

  // a takeover leaves the cpu marked occupied
  a_takeover_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GATE && in_range && is_rt) |=> occ_r[$past(idx)])
    else $error("realtime switch did not mark the cpu");

endmodule
